// File: sv/pbu_pkg.sv
`default_nettype none

package pbu_pkg;

   localparam int VALUE_W     = 24;
   localparam int GRID_WIDTH  = 32;
   localparam int GRID_HEIGHT = 32;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]                opcode;
      logic [4:0]                col;
      logic [4:0]                row;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic                      is_read;
   } rsp_type;

   localparam logic [2:0] REG_STEP_GAIN = 3'd0;

endpackage

`default_nettype wire

// File: sv/plate_biharmonic_update.sv
`default_nettype none

// Throughput: one request at a time; the step is bound by the single read port of the
//   current bank (1 cell/cycle).
// Reset: synchronous; clears step_gain and selects bank a, then sweeps both
//   banks to zero with req_ready low.
module plate_biharmonic_update
   import pbu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CELLS    = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW       = $clog2(CELLS);
   localparam int LEAD_END = CELLS + 2 * GRID_WIDTH;
   localparam int NW       = $clog2(LEAD_END + 1);
   localparam int XW       = $clog2(GRID_WIDTH);
   localparam int YW       = $clog2(GRID_HEIGHT);
   localparam int LINE_LEN = 4 * GRID_WIDTH + 1;
   localparam int SUM_W    = 30;
   localparam int PROD_W   = 63;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_DONE
   } state_type;

   state_type state_ff;

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic [31:0] step_gain_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_STEP_GAIN) ? step_gain_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_gain_ff <= 32'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         step_gain_ff <= csr_pwdata;
      end
   end

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   logic          req_fire;
   logic          req_inside;
   logic [AW-1:0] req_addr;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign req_inside = (int'(req_data.col) < GRID_WIDTH) && (int'(req_data.row) < GRID_HEIGHT);
   assign req_addr   = AW'(int'(req_data.row) * GRID_WIDTH + int'(req_data.col));

   // ---------------------------------------------------------------
   // Step pipeline registers
   //   issue: current-bank read of the lead cell
   //   shift: lead cell enters the line of 4 rows + 1
   //   a: stencil sum, previous-bank read of the centre cell
   //   b: gain product
   //   c: rounded, saturated term
   //   d: write back of the new cell into the previous bank
   // ---------------------------------------------------------------
   logic                       cur_bank_ff;
   logic [NW-1:0]              n_ff;
   logic                       iss_vld_ff, iss_in_ff, iss_ctr_ff;
   logic                       sh_vld_ff;
   logic [XW-1:0]              cx_ff;
   logic [YW-1:0]              cy_ff;
   logic [AW-1:0]              ctr_addr_ff;
   logic signed [VALUE_W-1:0]  line_ff [0:LINE_LEN-1];

   logic                       a_vld_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [VALUE_W-1:0]  a_c_ff;
   logic [AW-1:0]              a_addr_ff;

   logic                       b_vld_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [VALUE_W-1:0]  b_c_ff, b_prev_ff;
   logic [AW-1:0]              b_addr_ff;

   logic                       c_vld_ff;
   logic signed [VALUE_W-1:0]  term_ff, c_c_ff, c_prev_ff;
   logic [AW-1:0]              c_addr_ff;

   logic signed [VALUE_W-1:0]  q_a_ff, q_b_ff;
   logic signed [VALUE_W-1:0]  cur_q, prv_q;

   assign cur_q = cur_bank_ff ? q_b_ff : q_a_ff;
   assign prv_q = cur_bank_ff ? q_a_ff : q_b_ff;

   // stencil taps, zero where they fall off the plate
   logic signed [SUM_W-1:0] t_c, t_xm2, t_xm1, t_xp1, t_xp2, t_ym2, t_ym1, t_yp1, t_yp2;
   logic signed [SUM_W-1:0] sum_in;

   always_comb begin
      t_c   = SUM_W'(line_ff[2*GRID_WIDTH]);
      t_xp2 = (int'(cx_ff) <= GRID_WIDTH - 3)  ? SUM_W'(line_ff[2*GRID_WIDTH-2]) : '0;
      t_xp1 = (int'(cx_ff) <= GRID_WIDTH - 2)  ? SUM_W'(line_ff[2*GRID_WIDTH-1]) : '0;
      t_xm1 = (int'(cx_ff) >= 1)               ? SUM_W'(line_ff[2*GRID_WIDTH+1]) : '0;
      t_xm2 = (int'(cx_ff) >= 2)               ? SUM_W'(line_ff[2*GRID_WIDTH+2]) : '0;
      t_yp2 = (int'(cy_ff) <= GRID_HEIGHT - 3) ? SUM_W'(line_ff[0])              : '0;
      t_yp1 = (int'(cy_ff) <= GRID_HEIGHT - 2) ? SUM_W'(line_ff[GRID_WIDTH])     : '0;
      t_ym1 = (int'(cy_ff) >= 1)               ? SUM_W'(line_ff[3*GRID_WIDTH])   : '0;
      t_ym2 = (int'(cy_ff) >= 2)               ? SUM_W'(line_ff[4*GRID_WIDTH])   : '0;
      sum_in = t_xm2 + t_xp2 + t_ym2 + t_yp2
             - ((t_xm1 + t_xp1 + t_ym1 + t_yp1) <<< 2)
             + (t_c <<< 3) + (t_c <<< 2);
   end

   logic signed [PROD_W-1:0] prod_in;
   assign prod_in = $signed({1'b0, step_gain_ff}) * sum_ff;

   // round to nearest, ties up, then saturate
   logic signed [PROD_W-1:0]    rnd;
   logic signed [PROD_W-25:0]   shifted;
   logic signed [VALUE_W-1:0]   term_in;

   always_comb begin
      rnd     = prod_ff + PROD_W'(64'sd8388608);
      shifted = (PROD_W-24)'(rnd >>> 24);
      if (shifted > (PROD_W-24)'(64'sd8388607)) begin
         term_in = 24'sh7FFFFF;
      end else if (shifted < -(PROD_W-24)'(64'sd8388608)) begin
         term_in = 24'sh800000;
      end else begin
         term_in = VALUE_W'(shifted);
      end
   end

   logic signed [26:0]          next_wide;
   logic signed [VALUE_W-1:0]   next_in;

   always_comb begin
      next_wide = (27'(c_c_ff) <<< 1) - 27'(c_prev_ff) - 27'(term_ff);
      if (next_wide > 27'sd8388607) begin
         next_in = 24'sh7FFFFF;
      end else if (next_wide < -27'sd8388608) begin
         next_in = 24'sh800000;
      end else begin
         next_in = VALUE_W'(next_wide);
      end
   end

   // ---------------------------------------------------------------
   // Memory port steering
   // ---------------------------------------------------------------
   logic [AW-1:0]             cur_rd_addr;
   logic [AW-1:0]             rd_addr_a, rd_addr_b;
   logic                      we_a, we_b;
   logic [AW-1:0]             wa_addr, wb_addr;
   logic signed [VALUE_W-1:0] wa_data, wb_data;

   always_comb begin
      cur_rd_addr = (state_ff == ST_STEP) ? n_ff[AW-1:0] : req_addr;
      rd_addr_a   = cur_bank_ff ? ctr_addr_ff : cur_rd_addr;
      rd_addr_b   = cur_bank_ff ? cur_rd_addr : ctr_addr_ff;

      we_a    = 1'b0;
      we_b    = 1'b0;
      wa_addr = c_addr_ff;
      wb_addr = c_addr_ff;
      wa_data = next_in;
      wb_data = next_in;
      if (state_ff == ST_CLEAR) begin
         we_a    = 1'b1;
         we_b    = 1'b1;
         wa_addr = n_ff[AW-1:0];
         wb_addr = n_ff[AW-1:0];
         wa_data = '0;
         wb_data = '0;
      end else if (req_fire && req_data.opcode == OP_WRITE && req_inside) begin
         we_a    = !cur_bank_ff;
         we_b    = cur_bank_ff;
         wa_addr = req_addr;
         wb_addr = req_addr;
         wa_data = req_data.value;
         wb_data = req_data.value;
      end else if (c_vld_ff) begin
         // write back lands in the previous bank
         we_a = cur_bank_ff;
         we_b = !cur_bank_ff;
      end
   end

   logic signed [VALUE_W-1:0] bank_a [0:CELLS-1];
   logic signed [VALUE_W-1:0] bank_b [0:CELLS-1];

   always_ff @(posedge clock) begin
      if (we_a) begin
         bank_a[wa_addr] <= wa_data;
      end
      q_a_ff <= bank_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         bank_b[wb_addr] <= wb_data;
      end
      q_b_ff <= bank_b[rd_addr_b];
   end

   // ---------------------------------------------------------------
   // Datapath registers, no reset
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (iss_vld_ff) begin
         line_ff[0] <= iss_in_ff ? cur_q : '0;
         for (int i = 1; i < LINE_LEN; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
      sum_ff    <= sum_in;
      a_c_ff    <= line_ff[2*GRID_WIDTH];
      a_addr_ff <= ctr_addr_ff;
      prod_ff   <= prod_in;
      b_c_ff    <= a_c_ff;
      b_prev_ff <= prv_q;
      b_addr_ff <= a_addr_ff;
      term_ff   <= term_in;
      c_c_ff    <= b_c_ff;
      c_prev_ff <= b_prev_ff;
      c_addr_ff <= b_addr_ff;
   end

   // ---------------------------------------------------------------
   // Control and response register
   // ---------------------------------------------------------------
   logic                      rd_inside_ff;
   logic                      pend_rd_ff;
   logic signed [VALUE_W-1:0] pend_val_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;
   logic                      step_idle;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign step_idle = (n_ff == NW'(LEAD_END)) && !iss_vld_ff && !sh_vld_ff
                      && !a_vld_ff && !b_vld_ff && !c_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_bank_ff  <= 1'b0;
         n_ff         <= '0;
         iss_vld_ff   <= 1'b0;
         iss_in_ff    <= 1'b0;
         iss_ctr_ff   <= 1'b0;
         sh_vld_ff    <= 1'b0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         ctr_addr_ff  <= '0;
         rd_inside_ff <= 1'b0;
         pend_rd_ff   <= 1'b0;
         pend_val_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         iss_vld_ff <= 1'b0;
         sh_vld_ff  <= iss_vld_ff && iss_ctr_ff;
         a_vld_ff   <= sh_vld_ff;
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;

         if (sh_vld_ff) begin
            ctr_addr_ff <= ctr_addr_ff + AW'(1);
            if (int'(cx_ff) == GRID_WIDTH - 1) begin
               cx_ff <= '0;
               cy_ff <= cy_ff + YW'(1);
            end else begin
               cx_ff <= cx_ff + XW'(1);
            end
         end

         case (state_ff)
            ST_CLEAR: begin
               if (n_ff == NW'(CELLS - 1)) begin
                  n_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  n_ff <= n_ff + NW'(1);
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  pend_rd_ff  <= 1'b0;
                  pend_val_ff <= '0;
                  case (req_data.opcode)
                     OP_READ: begin
                        rd_inside_ff <= req_inside;
                        state_ff     <= ST_READ;
                     end
                     OP_STEP: begin
                        n_ff        <= '0;
                        cx_ff       <= '0;
                        cy_ff       <= '0;
                        ctr_addr_ff <= '0;
                        state_ff    <= ST_STEP;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               pend_rd_ff  <= 1'b1;
               pend_val_ff <= rd_inside_ff ? cur_q : '0;
               state_ff    <= ST_DONE;
            end
            ST_STEP: begin
               if (n_ff != NW'(LEAD_END)) begin
                  iss_vld_ff <= 1'b1;
                  iss_in_ff  <= (n_ff < NW'(CELLS));
                  iss_ctr_ff <= (n_ff >= NW'(2 * GRID_WIDTH));
                  n_ff       <= n_ff + NW'(1);
               end else if (step_idle) begin
                  cur_bank_ff <= !cur_bank_ff;
                  state_ff    <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.read_value <= pend_val_ff;
                  rsp_data_ff.is_read    <= pend_rd_ff;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_bank_stable_in_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && $past(state_ff == ST_STEP)) |-> $stable(cur_bank_ff))
      else $error("bank select moved during a step");

   a_writeback_in_step: assert property (@(posedge clock) disable iff (reset)
      c_vld_ff |-> state_ff == ST_STEP)
      else $error("write back outside a step");

   a_bank_flips_after_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && $past(state_ff == ST_STEP))
      |-> cur_bank_ff != $past(cur_bank_ff))
      else $error("banks not swapped at end of step");

endmodule

`default_nettype wire

// File: dv/plate_biharmonic_update_test.sv
`timescale 1ns / 100ps

module plate_biharmonic_update_test;
   import pbu_pkg::*;

   localparam int GW = 32;
   localparam int GH = 32;
   localparam int CELLS = GW * GH;
   localparam logic signed [23:0] VMAX = 24'sh7FFFFF;
   localparam logic signed [23:0] VMIN = -24'sh800000;
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   plate_biharmonic_update dut (.*);

   // plate model: two banks, one flag picks the current one
   logic signed [23:0] plate_a [CELLS];
   logic signed [23:0] plate_b [CELLS];
   logic               bank_sel;
   logic [31:0]        gain;

   req_type request_queue [$];
   rsp_type expected_rsps [$];
   int      fail_count;
   bit      stimulus_done;
   bit      hold_rsp;       // receiver hold-off, in force while set
   bit      sender_pause;   // sender waits for the model to drain

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // outside cell reads as zero
   function automatic longint plate_cell(input int x, input int y);
      if (x < 0 || x >= GW || y < 0 || y >= GH)
         return 0;
      return bank_sel ? longint'(plate_b[y*GW+x]) : longint'(plate_a[y*GW+x]);
   endfunction

   function automatic longint clamp24(input longint v);
      if (v > longint'(VMAX)) return longint'(VMAX);
      if (v < longint'(VMIN)) return longint'(VMIN);
      return v;
   endfunction

   // one time step of the plate; old previous grid becomes the next grid
   function automatic void plate_advance();
      longint c, dx, dy, p, term, nxt;
      logic signed [23:0] nxt_grid [CELLS];
      for (int y = 0; y < GH; y++)
         for (int x = 0; x < GW; x++) begin
            c  = plate_cell(x, y);
            dx = plate_cell(x-2, y) - 4*plate_cell(x-1, y) + 6*c
               - 4*plate_cell(x+1, y) + plate_cell(x+2, y);
            dy = plate_cell(x, y-2) - 4*plate_cell(x, y-1) + 6*c
               - 4*plate_cell(x, y+1) + plate_cell(x, y+2);
            p = longint'({32'd0, gain}) * (dx + dy);
            term = clamp24((p + 64'sd8388608) >>> 24);   // nearest, ties up
            nxt = 2*c - (bank_sel ? longint'(plate_a[y*GW+x])
                                  : longint'(plate_b[y*GW+x])) - term;
            nxt_grid[y*GW+x] = 24'(clamp24(nxt));
         end
      for (int i = 0; i < CELLS; i++)
         if (bank_sel) plate_a[i] = nxt_grid[i];
         else          plate_b[i] = nxt_grid[i];
      bank_sel = ~bank_sel;
   endfunction

   function automatic rsp_type plate_predict(input req_type r);
      rsp_type o;
      int      i;
      o = '0;
      i = r.row * GW + r.col;
      case (r.opcode)
         OP_WRITE: begin
            if (bank_sel) plate_b[i] = r.value;
            else          plate_a[i] = r.value;
         end
         OP_READ: begin
            o.is_read    = 1'b1;
            o.read_value = bank_sel ? plate_b[i] : plate_a[i];
         end
         OP_STEP: plate_advance();
         default: ;
      endcase
      return o;
   endfunction

   // driver: model updated on acceptance
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (req_valid && !req_ready) begin
         // held until accepted
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(plate_predict(req_data));
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (request_queue.size() > 0 && !sender_pause) begin
            req_data  <= request_queue.pop_front();
            req_valid <= 1'b1;
            gap_left  <= ($urandom_range(0, 3) == 0) ?
                         (($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(1, 3)) : 0;
         end else
            req_valid <= 1'b0;
      end
   end

   // monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected");
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.read_value !== e.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         e.read_value, rsp_data.read_value);
                  fail_count++;
               end
               if (rsp_data.is_read !== e.is_read) begin
                  $error("is_read: expected %0d, got %0d", e.is_read, rsp_data.is_read);
                  fail_count++;
               end
            end
         end
         if (hold_rsp)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= ($urandom_range(0, 4) != 0) ||
                         (stimulus_done && expected_rsps.size() > 0);
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      gain = data;
   endtask

   task automatic push_req(input logic [1:0] op, input int c, input int r,
                           input logic [23:0] v);
      req_type q;
      q.opcode = op;
      q.col    = 5'(c);
      q.row    = 5'(r);
      q.value  = v;
      request_queue.push_back(q);
   endtask

   // wait for the queue and the block to drain; step latency margin after
   task automatic wait_idle();
      while (request_queue.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // strike a few cells, step a few times, read some back, issue the spare opcode
   task automatic random_burst(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 40)
            push_req(OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                     ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1)) ? VMAX : VMIN)
                                                 : 24'($urandom));
         else if (pick < 85)
            push_req(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31), 24'($urandom));
         else if (pick < 93)
            push_req(OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31), 24'($urandom));
         else
            push_req(OP_SPARE, $urandom_range(0, 31), $urandom_range(0, 31), 24'($urandom));
      end
   endtask

   initial begin
      logic [31:0] gains [6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      fail_count = 0;
      stimulus_done = 1'b0;
      hold_rsp = 1'b0;
      sender_pause = 1'b0;
      bank_sel = 1'b0;
      gain = '0;
      for (int i = 0; i < CELLS; i++) begin
         plate_a[i] = '0;
         plate_b[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, extremes, outside reads via edges, spare opcode, step
      csr_write(REG_STEP_GAIN, 32'h0040_0000);
      push_req(OP_WRITE, 0, 0, VMAX);
      push_req(OP_WRITE, 31, 31, VMIN);
      push_req(OP_WRITE, 31, 0, 24'h155555);
      push_req(OP_WRITE, 0, 31, 24'hAAAAAA);
      push_req(OP_WRITE, 16, 16, VMAX);
      push_req(OP_READ, 0, 0, '0);
      push_req(OP_READ, 31, 31, 24'hFFFFFF);
      push_req(OP_READ, 31, 0, '0);
      push_req(OP_READ, 0, 31, '0);
      push_req(OP_SPARE, 31, 31, 24'hFFFFFF);
      push_req(OP_STEP, 0, 0, '0);
      push_req(OP_READ, 16, 16, '0);
      push_req(OP_READ, 15, 16, '0);
      push_req(OP_READ, 0, 0, '0);
      push_req(OP_STEP, 0, 0, '0);
      push_req(OP_READ, 16, 14, '0);
      push_req(OP_READ, 1, 1, '0);
      wait_idle();

      // sweep gain settings, extremes among them
      gains[0] = 32'd0;
      gains[1] = 32'hFFFF_FFFF;
      gains[2] = 32'h0000_0001;
      gains[3] = 32'h0100_0000;
      gains[4] = 32'h0008_0000;
      gains[5] = $urandom;
      foreach (gains[g]) begin
         csr_write(REG_STEP_GAIN, gains[g]);
         random_burst(94);
         if (g == 2) begin
            // receiver holds off so the block backs up
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (g == 3) begin
            // sender pauses until every expected response is in
            while (request_queue.size() > 50) @(posedge clock);
            sender_pause = 1'b1;
            while (req_valid || expected_rsps.size() > 0) @(posedge clock);
            sender_pause = 1'b0;
         end
         wait_idle();
      end

      stimulus_done = 1'b1;
      wait_idle();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // timeout covers the steps plus the reset sweep and stalls
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
